// ----- src/ceb_pkg.sv -----
// ----------------------------------------------------------------------------
// ceb_pkg: shared types and constants of the coincidence event builder
// Field widths, reset values, the hit word and the closed event word.
// ----------------------------------------------------------------------------
package ceb_pkg;

    localparam int CEB_TIME_W   = 48;
    localparam int CEB_CH_W     = 2;
    localparam int CEB_HEIGHT_W = 10;
    localparam int CEB_COUNT_W  = 8;
    localparam int CEB_WINDOW_W = 32;

    // Number of equipped detector channels, and channels shown in an event
    localparam int CEB_NUM_CH = 4;
    localparam int CEB_OUT_CH = 4;

    localparam logic [CEB_WINDOW_W-1:0] CEB_WINDOW_RESET = CEB_WINDOW_W'(1000);
    localparam logic [CEB_COUNT_W-1:0]  CEB_COUNT_MAX    = '1;
    localparam logic [CEB_COUNT_W-1:0]  CEB_TRIPLE_COUNT = CEB_COUNT_W'(3);

    // One detector hit
    typedef struct packed {
        logic [CEB_TIME_W-1:0]   hit_time;
        logic [CEB_CH_W-1:0]     channel;
        logic [CEB_HEIGHT_W-1:0] pulse_height;
    } t_hit;

    // One closed event
    typedef struct packed {
        logic [CEB_COUNT_W-1:0]                   hit_count;
        logic [CEB_OUT_CH-1:0][CEB_HEIGHT_W-1:0]  height;
        logic [CEB_OUT_CH-1:0][CEB_TIME_W-1:0]    stamp;
        logic                                     is_triple;
    } t_event;

endpackage

// ----- src/ceb_core.sv -----
// ----------------------------------------------------------------------------
// ceb_core: event state and window decision
// Holds the open event (count, per-channel slots, previous time), decides
// join or close for the presented hit and forms the closed event word.
// ----------------------------------------------------------------------------
module ceb_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [ceb_pkg::CEB_WINDOW_W-1:0]  i_window,
    input  ceb_pkg::t_hit                     i_hit,
    output logic                              o_emit,
    output ceb_pkg::t_event                   o_event
);
    import ceb_pkg::*;

    logic [CEB_TIME_W-1:0]   r_prev_time;
    logic [CEB_COUNT_W-1:0]  r_count;
    logic [CEB_HEIGHT_W-1:0] r_slot_height [CEB_NUM_CH];
    logic [CEB_TIME_W-1:0]   r_slot_time   [CEB_NUM_CH];

    logic [CEB_TIME_W-1:0]   diff;
    logic                    join_event;

    // Signed gap below window: a backwards step always joins
    assign diff       = i_hit.hit_time - r_prev_time;
    assign join_event = (i_hit.hit_time < r_prev_time)
                     || (diff < CEB_TIME_W'(i_window));

    assign o_emit = !join_event && (r_count != '0);

    // Closed event word from the current slots
    always_comb begin
        o_event.hit_count = r_count;
        o_event.is_triple = (r_count == CEB_TRIPLE_COUNT);
        for (int j = 0; j < CEB_OUT_CH; j++) begin
            o_event.height[j] = '0;
            o_event.stamp[j]  = '0;
            if (j < CEB_NUM_CH) begin
                o_event.height[j] = r_slot_height[j];
                o_event.stamp[j]  = r_slot_time[j];
            end
        end
    end

    // State update, one hit per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_count     <= '0;
            for (int i = 0; i < CEB_NUM_CH; i++) begin
                r_slot_height[i] <= '0;
                r_slot_time[i]   <= '0;
            end
        end else if (i_step) begin
            r_prev_time <= i_hit.hit_time;
            if (join_event) begin
                if (r_count != CEB_COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end else begin
                r_count <= CEB_COUNT_W'(1);
            end
            for (int i = 0; i < CEB_NUM_CH; i++) begin
                if (32'(i_hit.channel) == i) begin
                    r_slot_height[i] <= i_hit.pulse_height;
                    r_slot_time[i]   <= i_hit.hit_time;
                end else if (!join_event) begin
                    r_slot_height[i] <= '0;
                    r_slot_time[i]   <= '0;
                end
            end
        end
    end

endmodule

// ----- src/coincidence_event_builder.sv -----
// Path: a hit word is registered at acceptance and resolved against the
// open event from the input register; a closed event word is then registered
// in the output word register, later only while an earlier word is not taken.
// Throughput: one hit per cycle; the input stalls only when a closing hit
// meets an output word that is still not taken. Synchronous active-low reset
// empties both registers, clears the event state and sets the window to 1000.
// ----------------------------------------------------------------------------
// coincidence_event_builder: coincidence window event builder
// Groups time-ordered hits whose gap to the previous hit is below the
// configured window and emits each closed event as one output word.
// ----------------------------------------------------------------------------
module coincidence_event_builder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ceb_pkg::CEB_WINDOW_W-1:0]  i_coincidence_window,
    // hit input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ceb_pkg::CEB_TIME_W-1:0]    i_hit_time,
    input  logic [ceb_pkg::CEB_CH_W-1:0]      i_channel,
    input  logic [ceb_pkg::CEB_HEIGHT_W-1:0]  i_pulse_height,
    // event output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ceb_pkg::CEB_COUNT_W-1:0]   o_hit_count,
    output logic [ceb_pkg::CEB_HEIGHT_W-1:0]  o_height_ch0,
    output logic [ceb_pkg::CEB_HEIGHT_W-1:0]  o_height_ch1,
    output logic [ceb_pkg::CEB_HEIGHT_W-1:0]  o_height_ch2,
    output logic [ceb_pkg::CEB_HEIGHT_W-1:0]  o_height_ch3,
    output logic [ceb_pkg::CEB_TIME_W-1:0]    o_stamp_ch0,
    output logic [ceb_pkg::CEB_TIME_W-1:0]    o_stamp_ch1,
    output logic [ceb_pkg::CEB_TIME_W-1:0]    o_stamp_ch2,
    output logic [ceb_pkg::CEB_TIME_W-1:0]    o_stamp_ch3,
    output logic                              o_is_triple
);
    import ceb_pkg::*;

    logic [CEB_WINDOW_W-1:0] r_window;
    logic                    r_in_valid;
    t_hit                    r_in;
    logic                    r_out_valid;
    t_event                  r_out;

    logic   core_emit;
    t_event core_event;
    logic   out_free;
    logic   step;

    // Window register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= CEB_WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_window <= i_coincidence_window;
        end
    end

    // Handshake: a hit leaves the input register unless it closes an event
    // while the output word is still held
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && (!core_emit || out_free);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.hit_time     <= i_hit_time;
            r_in.channel      <= i_channel;
            r_in.pulse_height <= i_pulse_height;
        end
    end

    ceb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_window (r_window),
        .i_hit    (r_in),
        .o_emit   (core_emit),
        .o_event  (core_event)
    );

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && core_emit) begin
            r_out <= core_event;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit_count  = r_out.hit_count;
    assign o_height_ch0 = r_out.height[0];
    assign o_height_ch1 = r_out.height[1];
    assign o_height_ch2 = r_out.height[2];
    assign o_height_ch3 = r_out.height[3];
    assign o_stamp_ch0  = r_out.stamp[0];
    assign o_stamp_ch1  = r_out.stamp[1];
    assign o_stamp_ch2  = r_out.stamp[2];
    assign o_stamp_ch3  = r_out.stamp[3];
    assign o_is_triple  = r_out.is_triple;

endmodule

// ----- src/ceb_checker.sv -----
// ----------------------------------------------------------------------------
// ceb_checker: port-level checks of the coincidence event builder
// Watches the top level's ports and flags handshake and event word slips.
// ----------------------------------------------------------------------------
module ceb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic [ceb_pkg::CEB_COUNT_W-1:0]   o_hit_count,
    input  logic [ceb_pkg::CEB_TIME_W-1:0]    o_stamp_ch0,
    input  logic                              o_is_triple
);
    import ceb_pkg::*;

    // A word not taken stays on the port
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit_count)
            && $stable(o_stamp_ch0))
        else $error("output word dropped or changed while stalled");

    // Triple flag follows the count
    a_triple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_triple == (o_hit_count == CEB_TRIPLE_COUNT)))
        else $error("triple flag disagrees with hit count");

    // No empty event is emitted
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hit_count != '0))
        else $error("empty event emitted");

    // With the output register empty the input never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with output register empty");

endmodule

bind coincidence_event_builder ceb_checker u_ceb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_hit_count (o_hit_count),
    .o_stamp_ch0 (o_stamp_ch0),
    .o_is_triple (o_is_triple)
);

// ----- tb/coincidence_event_builder_test.sv -----
// ----------------------------------------------------------------------------
// coincidence_event_builder_test: self-checking bench of the event builder
// Drives hit words and window writes with random gaps and output stalls,
// predicts every closed event word in a scoreboard, and compares each output
// word field by field against the oldest predicted event.
// ----------------------------------------------------------------------------
module coincidence_event_builder_test;
    import ceb_pkg::*;

    localparam int DRAIN_SLACK    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_HITS     = 250;

    // Event prediction and checking
    class event_scoreboard;
        logic [CEB_WINDOW_W-1:0] window;
        logic [CEB_TIME_W-1:0]   last_hit_time;
        logic [CEB_COUNT_W-1:0]  open_hits;
        logic [CEB_HEIGHT_W-1:0] slot_height [CEB_NUM_CH];
        logic [CEB_TIME_W-1:0]   slot_stamp [CEB_NUM_CH];
        t_event                  closed_q [$];
        int                      errors;

        function new();
            window        = CEB_WINDOW_RESET;
            last_hit_time = '0;
            open_hits     = '0;
            errors        = 0;
            clear_slots();
        endfunction

        function void clear_slots();
            foreach (slot_height[i]) begin
                slot_height[i] = '0;
                slot_stamp[i]  = '0;
            end
        endfunction

        function void set_window(logic [CEB_WINDOW_W-1:0] w);
            window = w;
        endfunction

        function int pending();
            return closed_q.size();
        endfunction

        // Accepted hit: join the open event or close it
        function void note_hit(logic [CEB_TIME_W-1:0] t, logic [CEB_CH_W-1:0] ch,
                               logic [CEB_HEIGHT_W-1:0] h);
            longint gap;
            t_event ev;
            gap = longint'({16'b0, t}) - longint'({16'b0, last_hit_time});
            if (gap < longint'({32'b0, window})) begin
                if (open_hits != CEB_COUNT_MAX)
                    open_hits++;
            end else begin
                // nothing to emit for the very first hit after reset
                if (open_hits != 0) begin
                    ev.hit_count = open_hits;
                    for (int j = 0; j < CEB_OUT_CH; j++) begin
                        ev.height[j] = (j < CEB_NUM_CH) ? slot_height[j] : '0;
                        ev.stamp[j]  = (j < CEB_NUM_CH) ? slot_stamp[j] : '0;
                    end
                    ev.is_triple = (open_hits == CEB_TRIPLE_COUNT);
                    closed_q.insert(closed_q.size(), ev);
                end
                clear_slots();
                open_hits = CEB_COUNT_W'(1);
            end
            if (ch < CEB_NUM_CH) begin
                slot_height[ch] = h;
                slot_stamp[ch]  = t;
            end
            last_hit_time = t;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_event(t_event got);
            t_event want;
            if (closed_q.size() == 0) begin
                errors++;
                $display("%0t: event word expected none actual count %0h", $time,
                         got.hit_count);
                return;
            end
            want = closed_q.pop_front();
            compare_field("hit_count", 64'(want.hit_count), 64'(got.hit_count));
            for (int j = 0; j < CEB_OUT_CH; j++) begin
                compare_field($sformatf("height_ch%0d", j), 64'(want.height[j]),
                              64'(got.height[j]));
                compare_field($sformatf("stamp_ch%0d", j), 64'(want.stamp[j]),
                              64'(got.stamp[j]));
            end
            compare_field("is_triple", 64'(want.is_triple), 64'(got.is_triple));
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CEB_WINDOW_W-1:0] i_coincidence_window;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [CEB_TIME_W-1:0]   i_hit_time;
    logic [CEB_CH_W-1:0]     i_channel;
    logic [CEB_HEIGHT_W-1:0] i_pulse_height;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [CEB_COUNT_W-1:0]  o_hit_count;
    logic [CEB_HEIGHT_W-1:0] o_height_ch0, o_height_ch1, o_height_ch2, o_height_ch3;
    logic [CEB_TIME_W-1:0]   o_stamp_ch0, o_stamp_ch1, o_stamp_ch2, o_stamp_ch3;
    logic                    o_is_triple;

    event_scoreboard         event_sb = new();
    logic [CEB_TIME_W-1:0]   stream_time;
    int                      burst_left;
    bit                      burst_busy;
    int                      quiet_cycles = 0;

    coincidence_event_builder u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_coincidence_window (i_coincidence_window),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_hit_time           (i_hit_time),
        .i_channel            (i_channel),
        .i_pulse_height       (i_pulse_height),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_hit_count          (o_hit_count),
        .o_height_ch0         (o_height_ch0),
        .o_height_ch1         (o_height_ch1),
        .o_height_ch2         (o_height_ch2),
        .o_height_ch3         (o_height_ch3),
        .o_stamp_ch0          (o_stamp_ch0),
        .o_stamp_ch1          (o_stamp_ch1),
        .o_stamp_ch2          (o_stamp_ch2),
        .o_stamp_ch3          (o_stamp_ch3),
        .o_is_triple          (o_is_triple)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Sender spacing: stretches without gaps alternate with gappy ones
    function automatic int hit_spacing();
        if (burst_left == 0) begin
            burst_left = $urandom_range(20, 80);
            burst_busy = ($urandom_range(0, 2) == 0);
        end
        burst_left--;
        if (burst_busy || $urandom_range(0, 1) == 0)
            return 0;
        return idle_length();
    endfunction

    function automatic logic [CEB_HEIGHT_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CEB_HEIGHT_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Time step that keeps a hit in the open event (negative means backwards)
    function automatic longint join_step(logic [CEB_WINDOW_W-1:0] w);
        int r;
        r = $urandom_range(0, 9);
        if (w == 0 || r == 0)
            return -longint'($urandom_range(1, 1000));
        if (r == 1)
            return longint'(w) - 1;
        if (r == 2)
            return longint'($urandom_range(0, w - 1));
        return longint'($urandom_range(0, (w > 64) ? 63 : w - 1));
    endfunction

    // Time step that closes the open event
    function automatic longint close_step(logic [CEB_WINDOW_W-1:0] w);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return longint'(w);
        if (r == 9)
            return longint'(w) + longint'({$urandom_range(0, 255), $urandom});
        return longint'(w) + longint'($urandom_range(0, 5000));
    endfunction

    function automatic int event_size(bit force_long);
        if (force_long || $urandom_range(0, 399) == 0)
            return $urandom_range(256, 262);
        if ($urandom_range(0, 9) < 3)
            return 3;
        return $urandom_range(1, 6);
    endfunction

    // One hit word through the input handshake; ends on a falling edge
    task automatic send_hit(logic [CEB_TIME_W-1:0] t, logic [CEB_CH_W-1:0] ch,
                            logic [CEB_HEIGHT_W-1:0] h);
        int idle;
        idle = hit_spacing();
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_hit_time     <= t;
        i_channel      <= ch;
        i_pulse_height <= h;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        event_sb.note_hit(t, ch, h);
        stream_time = t;
        @(negedge i_clk);
    endtask

    task automatic write_window(logic [CEB_WINDOW_W-1:0] w);
        i_cfg_valid          <= 1'b1;
        i_coincidence_window <= w;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        event_sb.set_window(w);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every predicted event is out, then let it settle
    task automatic drain_events();
        i_in_valid <= 1'b0;
        while (event_sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    // Random events under the current window, with some noise hits
    task automatic run_phase(int hits, bit force_long);
        int sent;
        int size;
        longint step;
        logic [CEB_TIME_W-1:0] t;
        sent = 0;
        while (sent < hits) begin
            size = event_size(force_long);
            force_long = 1'b0;
            for (int k = 0; k < size; k++) begin
                // long events stay clean so the count reaches saturation
                if (size < 256 && $urandom_range(0, 99) < 6) begin
                    t = CEB_TIME_W'({$urandom, $urandom});
                end else begin
                    step = (k == 0) ? close_step(event_sb.window)
                                    : join_step(event_sb.window);
                    t = stream_time + step[CEB_TIME_W-1:0];
                end
                send_hit(t, CEB_CH_W'($urandom_range(0, 3)), pick_height());
                sent++;
                if (sent == hits / 2)
                    drain_events();
            end
        end
    endtask

    // Output side: random stalls, with long ready stretches now and then
    initial begin
        int run;
        bit rdy;
        run = 0;
        rdy = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run == 0) begin
                rdy = ($urandom_range(0, 3) != 0);
                if (!rdy)
                    run = idle_length();
                else if ($urandom_range(0, 19) == 0)
                    run = $urandom_range(50, 200);
                else
                    run = $urandom_range(1, 12);
            end
            run--;
            i_out_ready <= rdy;
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        t_event got;
        if (o_out_valid && i_out_ready) begin
            got.hit_count = o_hit_count;
            got.height    = {o_height_ch3, o_height_ch2, o_height_ch1, o_height_ch0};
            got.stamp     = {o_stamp_ch3, o_stamp_ch2, o_stamp_ch1, o_stamp_ch0};
            got.is_triple = o_is_triple;
            event_sb.check_event(got);
        end
    end

    // Watchdog: too long without any word moving on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        logic [CEB_WINDOW_W-1:0] windows [5];
        i_rst_n              = 1'b0;
        i_cfg_valid          = 1'b0;
        i_coincidence_window = '0;
        i_in_valid           = 1'b0;
        i_hit_time           = '0;
        i_channel            = '0;
        i_pulse_height       = '0;
        stream_time          = '0;
        burst_left           = 0;
        burst_busy           = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed hits under the reset window
        send_hit(48'd5000, 2'd0, 10'h3FF);              // first hit, empty event
        send_hit(48'd5999, 2'd1, 10'h000);              // one below the window
        send_hit(48'd6998, 2'd2, 10'h155);
        send_hit(48'd7998, 2'd3, 10'h2AA);              // gap equals window: triple
        send_hit(48'd7000, 2'd3, 10'd5);                // time going backwards
        send_hit(48'd7500, 2'd3, 10'd7);                // slot overwrite
        send_hit(48'd7600, 2'd0, 10'h3FF);
        send_hit(48'hFFFF_FFFF_FFFF, 2'd1, 10'h3FF);    // largest time
        send_hit(48'd0, 2'd2, 10'h000);                 // huge negative gap
        send_hit(48'hFFFF_FFFF_FFFF, 2'd0, 10'h3FF);
        send_hit(48'hFFFF_FFFF_FFFF, 2'd0, 10'h200);    // zero gap
        send_hit(48'h5555_5555_5555, 2'd1, 10'h155);
        send_hit(48'hAAAA_AAAA_AAAA, 2'd2, 10'h2AA);
        send_hit(48'hAAAA_AAAA_AE91, 2'd3, 10'd1);      // +999
        send_hit(48'hAAAA_AAAA_B279, 2'd1, 10'd2);      // +1000 closes

        run_phase(PHASE_HITS, 1'b1);

        windows[0] = '0;
        windows[1] = '1;
        windows[2] = CEB_WINDOW_W'(1);
        windows[3] = $urandom;
        windows[4] = $urandom_range(2, 5000);
        foreach (windows[p]) begin
            drain_events();
            write_window(windows[p]);
            run_phase(PHASE_HITS, 1'b0);
        end
        drain_events();

        if (event_sb.errors == 0 && event_sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- coincidence_event_builder.f -----
src/ceb_pkg.sv
src/ceb_core.sv
src/coincidence_event_builder.sv
src/ceb_checker.sv
tb/coincidence_event_builder_test.sv
